@@ hdl/plst_pkg.sv @@
// ----------------------------------------------------------------------------
// plst_pkg
// Types and codes shared by the positional list store modules.
// ----------------------------------------------------------------------------
`default_nettype none

package plst_pkg;

   localparam int CMD_W    = 3;
   localparam int POS_W    = 5;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 3;
   localparam int FOUND_W  = 4;
   localparam int COUNT_W  = 5;

   // command codes
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd4;
   localparam logic [CMD_W-1:0] CMD_ERASE      = 3'd5;
   localparam logic [CMD_W-1:0] CMD_FIND       = 3'd6;
   localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd7;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]          cmd;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FOUND_W-1:0]  found_index;
      logic [COUNT_W-1:0]  count;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch the accepted item
      logic exec;      // decode, shift cells, update count
      logic scan;      // one step of the find scan
      logic load_rsp;  // move the finished result to the output register
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_find;
      logic scan_done;
   } dp_status_type;

endpackage

`default_nettype wire

@@ hdl/positional_list_store.sv @@
// ----------------------------------------------------------------------------
// positional_list_store
// Fixed-capacity ordered list of signed values with push/pop at both ends,
// insert/erase at a position, find and clear. One result item per command.
// ----------------------------------------------------------------------------
//
//  channel  | ports                         | payload
//  ---------+-------------------------------+------------------------------
//  request  | req_valid, req_ready, req_data | cmd, position, value
//  response | rsp_valid, rsp_ready, rsp_data | status, found_index, count
//
// Steps: accept, execute (every cell shifts at once), then the result moves to
// the output register once the output slot is free; find adds a scan of the
// registered match vector between execute and that move, one entry per cycle.
// Reset clears the count and the handshake state; entries hold stale data.
// A new item is accepted once the previous result sits in the output
// register, even while that result is still stalled by rsp_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_store #(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  plst_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output plst_pkg::rsp_type   rsp_data
);
   import plst_pkg::*;

   ctrl_cmd_type  ctrl;
   dp_status_type dp_status;

   // sequencer: owns the handshakes and the output valid
   plst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctrl      (ctrl),
      .dp_status (dp_status)
   );

   // cell row, count, find scan and result registers
   plst_datapath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctrl      (ctrl),
      .dp_status (dp_status),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ hdl/plst_datapath.sv @@
// ----------------------------------------------------------------------------
// plst_datapath
// Cell row holding the list, count register, find scan and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module plst_datapath #(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire                      clock,
   input  wire                      reset,
   input  plst_pkg::req_type        req_data,
   input  plst_pkg::ctrl_cmd_type   ctrl,
   output plst_pkg::dp_status_type  dp_status,
   output plst_pkg::rsp_type        rsp_data
);
   import plst_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   req_type                req_ff;
   logic [DATA_WIDTH-1:0]  entries_ff [CAPACITY];
   logic [DATA_WIDTH-1:0]  entries_in [CAPACITY];
   logic [CNT_W-1:0]       fill_count_ff;
   logic [CNT_W-1:0]       fill_count_in;
   logic [CAPACITY-1:0]    match_ff;
   logic [CAPACITY-1:0]    match_in;
   logic [CNT_W-1:0]       scan_idx_ff;
   rsp_type                result_ff;
   rsp_type                rsp_ff;

   logic [DATA_WIDTH-1:0]  key;
   logic                   full;
   logic                   empty;
   logic [CMP_W-1:0]       pos_ext;
   logic [CMP_W-1:0]       fill_ext;
   logic                   do_open;
   logic                   do_close;
   logic [CNT_W-1:0]       at;
   logic [STATUS_W-1:0]    exec_status;

   assign key      = DATA_WIDTH'($unsigned(req_ff.value));
   assign full     = (fill_count_ff == CNT_W'(CAPACITY));
   assign empty    = (fill_count_ff == '0);
   assign pos_ext  = CMP_W'(req_ff.position);
   assign fill_ext = CMP_W'(fill_count_ff);

   // command decode
   always_comb begin
      do_open       = 1'b0;
      do_close      = 1'b0;
      at            = '0;
      exec_status   = ST_OK;
      fill_count_in = fill_count_ff;
      case (req_ff.cmd)
         CMD_PUSH_BACK: begin
            if (full) exec_status = ST_FULL;
            else begin
               do_open = 1'b1;
               at      = fill_count_ff;
            end
         end
         CMD_PUSH_FRONT: begin
            if (full) exec_status = ST_FULL;
            else do_open = 1'b1;
         end
         CMD_POP_BACK: begin
            if (empty) exec_status = ST_EMPTY;
            else fill_count_in = fill_count_ff - 1'b1;
         end
         CMD_POP_FRONT: begin
            if (empty) exec_status = ST_EMPTY;
            else do_close = 1'b1;
         end
         CMD_INSERT: begin
            // position is checked before fullness
            if (pos_ext > fill_ext) exec_status = ST_BADPOS;
            else if (full) exec_status = ST_FULL;
            else begin
               do_open = 1'b1;
               at      = CNT_W'(req_ff.position);
            end
         end
         CMD_ERASE: begin
            if (pos_ext >= fill_ext) exec_status = ST_BADPOS;
            else begin
               do_close = 1'b1;
               at       = CNT_W'(req_ff.position);
            end
         end
         CMD_FIND:  exec_status = ST_OK;
         CMD_CLEAR: fill_count_in = '0;
         default:   exec_status = ST_OK;
      endcase
      if (do_open)  fill_count_in = fill_count_ff + 1'b1;
      if (do_close) fill_count_in = fill_count_ff - 1'b1;
   end

   // cell row: each cell looks only at its two neighbors
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      always_comb begin
         entries_in[k] = entries_ff[k];
         if (do_open) begin
            if (CNT_W'(k) == at) entries_in[k] = key;
            if (k > 0) begin
               if (CNT_W'(k) > at) entries_in[k] = entries_ff[(k > 0) ? k - 1 : 0];
            end
         end
         if (do_close && (k < CAPACITY - 1)) begin
            if (CNT_W'(k) >= at)
               entries_in[k] = entries_ff[(k < CAPACITY - 1) ? k + 1 : k];
         end
         match_in[k] = (entries_ff[k] == key) && (CNT_W'(k) < fill_count_ff);
      end

      always_ff @(posedge clock) begin
         if (ctrl.exec) entries_ff[k] <= entries_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) fill_count_ff <= '0;
      else if (ctrl.exec) fill_count_ff <= fill_count_in;
   end

   // item latch, find scan, result and output registers
   always_ff @(posedge clock) begin
      if (ctrl.capture) req_ff <= req_data;
      if (ctrl.exec) begin
         match_ff    <= match_in;
         scan_idx_ff <= '0;
         result_ff   <= '{status: exec_status, found_index: '0,
                          count: COUNT_W'(fill_count_in)};
      end
      if (ctrl.scan) begin
         if (match_ff[0]) begin
            result_ff <= '{status: ST_OK, found_index: FOUND_W'(scan_idx_ff),
                           count: COUNT_W'(fill_count_ff)};
         end else if (scan_idx_ff == fill_count_ff) begin
            result_ff <= '{status: ST_NOTFOUND, found_index: '0,
                           count: COUNT_W'(fill_count_ff)};
         end else begin
            match_ff    <= match_ff >> 1;
            scan_idx_ff <= scan_idx_ff + 1'b1;
         end
      end
      if (ctrl.load_rsp) rsp_ff <= result_ff;
   end

   assign dp_status.is_find   = (req_ff.cmd == CMD_FIND);
   assign dp_status.scan_done = match_ff[0] || (scan_idx_ff == fill_count_ff);
   assign rsp_data            = rsp_ff;

   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= CNT_W'(CAPACITY))
      else $error("fill count above capacity");

endmodule

`default_nettype wire

@@ hdl/plst_ctrl.sv @@
// ----------------------------------------------------------------------------
// plst_ctrl
// Sequencer: accept, execute, scan for find, hand result to output register.
// ----------------------------------------------------------------------------
`default_nettype none

module plst_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output plst_pkg::ctrl_cmd_type   ctrl,
   input  plst_pkg::dp_status_type  dp_status
);
   import plst_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_HOLD = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      ctrl          = '0;
      ctrl.capture  = req_valid && req_ready;
      case (state_ff)
         S_IDLE: if (req_valid) state_in = S_EXEC;
         S_EXEC: begin
            ctrl.exec = 1'b1;
            state_in  = dp_status.is_find ? S_SCAN : S_HOLD;
         end
         S_SCAN: begin
            ctrl.scan = 1'b1;
            if (dp_status.scan_done) state_in = S_HOLD;
         end
         S_HOLD: begin
            if (slot_free) begin
               ctrl.load_rsp = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      ctrl.capture |=> state_ff == S_EXEC)
      else $error("accepted item not executed");

   a_exec_next: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXEC |=> state_ff == S_SCAN || state_ff == S_HOLD)
      else $error("bad state after execute");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      ctrl.load_rsp |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.load_rsp |-> slot_free)
      else $error("result overwrote a pending item");

endmodule

`default_nettype wire
